// ===== design/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg: shared definitions of the flow counter
// Table sizing, item and status codes, the stored entry layout and the table
// write request.
// ----------------------------------------------------------------------------
package ftc_pkg;

    localparam int FLOW_SLOTS = 64;
    localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int PKT_W      = 32;
    localparam int BYTE_W     = 48;

    localparam logic       MODE_COUNT = 1'b0;
    localparam logic       MODE_READ  = 1'b1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        STS_COUNTED    = 3'd0,
        STS_IGNORED    = 3'd1,
        STS_FULL       = 3'd2,
        STS_READ_VALID = 3'd3,
        STS_READ_EMPTY = 3'd4
    } t_status;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [7:0]        proto;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [PKT_W-1:0]  packets;
        logic [BYTE_W-1:0] bytes;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_slot  addr;
        t_entry data;
    } t_wr_req;

endpackage

// ===== design/ftc_table.sv =====
// ----------------------------------------------------------------------------
// ftc_table: flow table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ftc_table (
    input  logic             i_clk,
    input  ftc_pkg::t_wr_req i_wr,
    input  ftc_pkg::t_slot   i_rd_addr,
    output ftc_pkg::t_entry  o_rd_data
);
    import ftc_pkg::*;

    t_entry r_mem [FLOW_SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/ftc_update.sv =====
// ----------------------------------------------------------------------------
// ftc_update: saturating counter update
// Adds one packet and the payload length to a slot's counters, or starts
// them from zero for a newly allocated slot.
// ----------------------------------------------------------------------------
module ftc_update (
    input  logic                       i_clear,
    input  logic [ftc_pkg::PKT_W-1:0]  i_packets,
    input  logic [ftc_pkg::BYTE_W-1:0] i_bytes,
    input  logic [15:0]                i_pay,
    output logic [ftc_pkg::PKT_W-1:0]  o_packets,
    output logic [ftc_pkg::BYTE_W-1:0] o_bytes
);
    import ftc_pkg::*;

    logic [PKT_W-1:0]  base_pkt;
    logic [BYTE_W-1:0] base_bytes;
    logic [BYTE_W:0]   sum;

    always_comb begin
        base_pkt   = i_clear ? '0 : i_packets;
        base_bytes = i_clear ? '0 : i_bytes;
        sum        = {1'b0, base_bytes} + {{(BYTE_W + 1 - 16){1'b0}}, i_pay};
        o_packets  = (&base_pkt) ? base_pkt : base_pkt + PKT_W'(1);
        o_bytes    = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
    end

endmodule

// ===== design/flow_tuple_traffic_counter.sv =====
// ----------------------------------------------------------------------------
// flow_tuple_traffic_counter: per-flow packet and payload byte counter
// A read or an ignored packet has its result registered from ST_RDOUT or ST_EMIT
// once the output register is free; a packet first walks the filled slots of the
// table memory, one compare per cycle (at most FLOW_SLOTS of them), then
// registers its result from ST_UPD or ST_MISS. One item at a time; the next beat
// is taken once the result is registered, and a later result waits in its state
// while a stalled result beat keeps the output register full. Reset empties the
// table at once by clearing the fill count.
// ----------------------------------------------------------------------------
module flow_tuple_traffic_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [7:0]  i_protocol_number,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_total_length,
    input  logic [3:0]  i_header_words,
    input  logic [3:0]  i_tcp_offset_words,
    input  logic [5:0]  i_slot_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot_used,
    output logic [31:0] o_flow_source_address,
    output logic [31:0] o_flow_dest_address,
    output logic [7:0]  o_flow_protocol,
    output logic [15:0] o_flow_source_port,
    output logic [15:0] o_flow_dest_port,
    output logic [31:0] o_packets_seen,
    output logic [47:0] o_bytes_seen,
    output logic [15:0] o_payload_bytes
);
    import ftc_pkg::*;

    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_UPD   = 6'b000100,
        ST_MISS  = 6'b001000,
        ST_RDOUT = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [5:0]        slot_used;
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [7:0]        proto;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [PKT_W-1:0]  packets;
        logic [BYTE_W-1:0] bytes;
        logic [15:0]       pay;
    } t_result;

    function automatic logic [15:0] payload_len(logic [7:0] proto, logic [15:0] tot,
                                                logic [3:0] hw, logic [3:0] tw);
        logic [15:0] p;
        p = tot - {10'd0, hw, 2'b00};
        if (p == 16'd0) begin
            return 16'd0;
        end
        if (proto == PROTO_TCP) begin
            return p - {10'd0, tw, 2'b00};
        end
        return p - UDP_HDR_BYTES;
    endfunction

    function automatic t_slot idx_slot(logic [5:0] idx);
        logic [SLOT_W+5:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [5:0] slot_used(t_slot s);
        logic [SLOT_W+5:0] w;
        w = {6'd0, s};
        return w[5:0];
    endfunction

    t_state  r_state, n_state;
    t_count  r_filled, n_filled;
    logic    r_out_valid, n_out_valid;
    t_slot   r_ptr, n_ptr;
    t_result r_res, n_res;

    logic        r_mode;
    logic [31:0] r_src, r_dst;
    logic [7:0]  r_proto;
    logic [15:0] r_sport, r_dport, r_pay;
    logic [5:0]  r_idx;

    t_wr_req          wr;
    t_slot            rd_addr;
    t_entry           q;
    logic             upd_clear;
    logic [PKT_W-1:0] upd_packets;
    logic [BYTE_W-1:0] upd_bytes;
    logic             accept, out_free, hit, last, idx_ok, proto_ok, full;

    ftc_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (q)
    );

    ftc_update u_update (
        .i_clear   (upd_clear),
        .i_packets (q.packets),
        .i_bytes   (q.bytes),
        .i_pay     (r_pay),
        .o_packets (upd_packets),
        .o_bytes   (upd_bytes)
    );

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign hit      = (q.src_addr == r_src) && (q.dst_addr == r_dst) && (q.proto == r_proto)
                      && (q.src_port == r_sport) && (q.dst_port == r_dport);
    assign last     = (t_count'({1'b0, r_ptr}) + t_count'(1)) == r_filled;
    assign idx_ok   = {{CNT_W{1'b0}}, i_slot_index} < {6'd0, r_filled};
    assign proto_ok = (i_protocol_number == PROTO_TCP) || (i_protocol_number == PROTO_UDP);
    assign full     = (r_filled == t_count'(FLOW_SLOTS));

    always_comb begin
        n_state     = r_state;
        n_filled    = r_filled;
        n_ptr       = r_ptr;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_stall;
        rd_addr     = r_ptr;
        upd_clear   = 1'b0;
        wr          = '0;
        case (r_state)
            ST_IDLE: begin
                rd_addr = i_mode ? idx_slot(i_slot_index) : '0;
                if (accept) begin
                    n_ptr = '0;
                    if (i_mode) begin
                        n_state = idx_ok ? ST_RDOUT : ST_EMIT;
                    end else if (!proto_ok) begin
                        n_state = ST_EMIT;
                    end else if (r_filled == '0) begin
                        n_state = ST_MISS;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_UPD;
                end else if (last) begin
                    n_state = ST_MISS;
                end else begin
                    n_ptr   = r_ptr + t_slot'(1);
                    rd_addr = r_ptr + t_slot'(1);
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    wr.en   = 1'b1;
                    wr.addr = r_ptr;
                    wr.data = '{r_src, r_dst, r_proto, r_sport, r_dport,
                                upd_packets, upd_bytes};
                    n_res   = '{STS_COUNTED, slot_used(r_ptr), r_src, r_dst, r_proto,
                                r_sport, r_dport, upd_packets, upd_bytes, r_pay};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_MISS: begin
                upd_clear = 1'b1;
                if (out_free) begin
                    if (full) begin
                        n_res = '{STS_FULL, 6'd0, r_src, r_dst, r_proto, r_sport, r_dport,
                                  '0, '0, r_pay};
                    end else begin
                        wr.en    = 1'b1;
                        wr.addr  = r_filled[SLOT_W-1:0];
                        wr.data  = '{r_src, r_dst, r_proto, r_sport, r_dport,
                                     upd_packets, upd_bytes};
                        n_res    = '{STS_COUNTED, slot_used(r_filled[SLOT_W-1:0]), r_src,
                                     r_dst, r_proto, r_sport, r_dport, upd_packets,
                                     upd_bytes, r_pay};
                        n_filled = r_filled + t_count'(1);
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_RDOUT: begin
                rd_addr = idx_slot(r_idx);
                if (out_free) begin
                    n_res = '{STS_READ_VALID, r_idx, q.src_addr, q.dst_addr, q.proto,
                              q.src_port, q.dst_port, q.packets, q.bytes, 16'd0};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_res = '0;
                    if (r_mode) begin
                        n_res.status    = STS_READ_EMPTY;
                        n_res.slot_used = r_idx;
                    end else begin
                        n_res.status = STS_IGNORED;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_res <= n_res;
        if (accept) begin
            r_mode  <= i_mode;
            r_src   <= i_source_address;
            r_dst   <= i_dest_address;
            r_proto <= i_protocol_number;
            r_sport <= i_source_port;
            r_dport <= i_dest_port;
            r_idx   <= i_slot_index;
            r_pay   <= payload_len(i_protocol_number, i_total_length, i_header_words,
                                   i_tcp_offset_words);
        end
    end

    assign o_valid               = r_out_valid;
    assign o_status              = r_res.status;
    assign o_slot_used           = r_res.slot_used;
    assign o_flow_source_address = r_res.src_addr;
    assign o_flow_dest_address   = r_res.dst_addr;
    assign o_flow_protocol       = r_res.proto;
    assign o_flow_source_port    = r_res.src_port;
    assign o_flow_dest_port      = r_res.dst_port;
    assign o_packets_seen        = r_res.packets;
    assign o_bytes_seen          = r_res.bytes;
    assign o_payload_bytes       = r_res.pay;

endmodule

// ===== sim/ftc_flow_checker.sv =====
// ----------------------------------------------------------------------------
// ftc_flow_checker: result checker of the flow counter
// Watches both channels of the flow counter, keeps its own copy of the flow
// table, works out the result due for every input beat taken, and compares
// each result beat field by field with the oldest result still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ftc_flow_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [7:0]  i_protocol_number,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_total_length,
    input  logic [3:0]  i_header_words,
    input  logic [3:0]  i_tcp_offset_words,
    input  logic [5:0]  i_slot_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [5:0]  i_slot_used,
    input  logic [31:0] i_flow_source_address,
    input  logic [31:0] i_flow_dest_address,
    input  logic [7:0]  i_flow_protocol,
    input  logic [15:0] i_flow_source_port,
    input  logic [15:0] i_flow_dest_port,
    input  logic [31:0] i_packets_seen,
    input  logic [47:0] i_bytes_seen,
    input  logic [15:0] i_payload_bytes,
    output int          o_fail_count,
    output int          o_pending
);
    import ftc_pkg::*;

    localparam logic [15:0]      UDP_HDR   = 16'd8;
    localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        slot;
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [7:0]        proto;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [PKT_W-1:0]  packets;
        logic [BYTE_W-1:0] bytes;
        logic [15:0]       payload;
    } flow_report_t;

    t_entry       flow_table [FLOW_SLOTS];
    logic         slot_live [FLOW_SLOTS];
    int           slots_taken;
    flow_report_t due_reports [$];
    int           results_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        results_seen = 0;
        slots_taken  = 0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result beat %0d, %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
        end
    endtask

    function automatic flow_report_t with_entry(input flow_report_t r, input t_entry e);
        r.src_addr = e.src_addr;
        r.dst_addr = e.dst_addr;
        r.proto    = e.proto;
        r.src_port = e.src_port;
        r.dst_port = e.dst_port;
        r.packets  = e.packets;
        r.bytes    = e.bytes;
        return r;
    endfunction

    // Accounts the input beat now on the channel against the table copy.
    function automatic flow_report_t tally_item();
        flow_report_t r;
        t_entry       key;
        logic [15:0]  rest;
        logic [15:0]  pay;
        int           hit;
        r = '0;
        if (i_mode == MODE_READ) begin
            r.slot = i_slot_index;
            if (int'(i_slot_index) < FLOW_SLOTS && slot_live[i_slot_index]) begin
                r        = with_entry(r, flow_table[i_slot_index]);
                r.status = STS_READ_VALID;
            end else begin
                r.status = STS_READ_EMPTY;
            end
            return r;
        end
        if (i_protocol_number != PROTO_TCP && i_protocol_number != PROTO_UDP) begin
            r.status = STS_IGNORED;
            return r;
        end

        rest = i_total_length - {10'd0, i_header_words, 2'b00};
        if (rest == 16'd0) begin
            pay = 16'd0;
        end else if (i_protocol_number == PROTO_TCP) begin
            pay = rest - {10'd0, i_tcp_offset_words, 2'b00};
        end else begin
            pay = rest - UDP_HDR;
        end

        key = '{src_addr: i_source_address, dst_addr: i_dest_address,
                proto: i_protocol_number, src_port: i_source_port,
                dst_port: i_dest_port, packets: '0, bytes: '0};
        hit = -1;
        for (int s = 0; s < slots_taken; s++) begin
            if (slot_live[s] && flow_table[s].src_addr == key.src_addr &&
                flow_table[s].dst_addr == key.dst_addr && flow_table[s].proto == key.proto &&
                flow_table[s].src_port == key.src_port &&
                flow_table[s].dst_port == key.dst_port) begin
                hit = s;
                break;
            end
        end

        if (hit < 0) begin
            if (slots_taken >= FLOW_SLOTS) begin
                r         = with_entry(r, key);
                r.status  = STS_FULL;
                r.payload = pay;
                return r;
            end
            hit              = slots_taken;
            slots_taken      = slots_taken + 1;
            slot_live[hit]   = 1'b1;
            flow_table[hit]  = key;
        end

        if (flow_table[hit].packets != '1) begin
            flow_table[hit].packets = flow_table[hit].packets + 1'b1;
        end
        if (flow_table[hit].bytes > BYTE_MAX - BYTE_W'(pay)) begin
            flow_table[hit].bytes = BYTE_MAX;
        end else begin
            flow_table[hit].bytes = flow_table[hit].bytes + BYTE_W'(pay);
        end

        r         = with_entry(r, flow_table[hit]);
        r.status  = STS_COUNTED;
        r.slot    = t_slot'(hit);
        r.payload = pay;
        return r;
    endfunction

    always @(posedge i_clk) begin
        flow_report_t want;
        if (!i_rst_n) begin
            slots_taken = 0;
            foreach (slot_live[s]) begin
                slot_live[s] = 1'b0;
            end
            due_reports.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                due_reports.push_back(tally_item());
            end
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (due_reports.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with nothing due",
                                              results_seen));
                end else begin
                    want = due_reports.pop_front();
                    check_field("status", i_status, want.status);
                    check_field("slot_used", i_slot_used, want.slot);
                    check_field("flow_source_address", i_flow_source_address, want.src_addr);
                    check_field("flow_dest_address", i_flow_dest_address, want.dst_addr);
                    check_field("flow_protocol", i_flow_protocol, want.proto);
                    check_field("flow_source_port", i_flow_source_port, want.src_port);
                    check_field("flow_dest_port", i_flow_dest_port, want.dst_port);
                    check_field("packets_seen", i_packets_seen, want.packets);
                    check_field("bytes_seen", i_bytes_seen, want.bytes);
                    check_field("payload_bytes", i_payload_bytes, want.payload);
                end
            end
        end
        o_pending = due_reports.size();
    end

endmodule

// ===== sim/tb_flow_tuple_traffic_counter.sv =====
// ----------------------------------------------------------------------------
// tb_flow_tuple_traffic_counter: testbench of the flow counter
// Drives a short directed run through the payload length corner cases, the
// ignored protocols and slot reads, then random traffic built mostly from
// repeats of known flows, so that the table fills and later misses find it
// full. Both channels idle at random; the checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_flow_tuple_traffic_counter;
    import ftc_pkg::*;

    localparam int         RANDOM_ITEMS   = 1100;
    localparam int         CALM_ITEMS     = 150;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } flow_t;

    typedef struct packed {
        logic        mode;
        flow_t       flow;
        logic [15:0] total_length;
        logic [3:0]  header_words;
        logic [3:0]  tcp_words;
        logic [5:0]  slot_index;
    } item_t;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_valid            = 1'b0;
    logic        i_mode             = 1'b0;
    logic [31:0] i_source_address   = '0;
    logic [31:0] i_dest_address     = '0;
    logic [7:0]  i_protocol_number  = '0;
    logic [15:0] i_source_port      = '0;
    logic [15:0] i_dest_port        = '0;
    logic [15:0] i_total_length     = '0;
    logic [3:0]  i_header_words     = '0;
    logic [3:0]  i_tcp_offset_words = '0;
    logic [5:0]  i_slot_index       = '0;
    logic        i_stall            = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [5:0]  o_slot_used;
    logic [31:0] o_flow_source_address;
    logic [31:0] o_flow_dest_address;
    logic [7:0]  o_flow_protocol;
    logic [15:0] o_flow_source_port;
    logic [15:0] o_flow_dest_port;
    logic [31:0] o_packets_seen;
    logic [47:0] o_bytes_seen;
    logic [15:0] o_payload_bytes;

    int    fail_count;
    int    pending;
    bit    calm         = 1'b0;
    int    gap_rate     = 30;
    int    stall_rate   = 0;
    int    stall_left   = 0;
    int    stall_epoch  = 0;
    int    quiet_cycles = 0;
    flow_t known_flows [$];

    always #4 i_clk = ~i_clk;

    flow_tuple_traffic_counter dut (.*);

    ftc_flow_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_valid),
        .i_in_stall            (o_stall),
        .i_mode                (i_mode),
        .i_source_address      (i_source_address),
        .i_dest_address        (i_dest_address),
        .i_protocol_number     (i_protocol_number),
        .i_source_port         (i_source_port),
        .i_dest_port           (i_dest_port),
        .i_total_length        (i_total_length),
        .i_header_words        (i_header_words),
        .i_tcp_offset_words    (i_tcp_offset_words),
        .i_slot_index          (i_slot_index),
        .i_out_valid           (o_valid),
        .i_out_stall           (i_stall),
        .i_status              (o_status),
        .i_slot_used           (o_slot_used),
        .i_flow_source_address (o_flow_source_address),
        .i_flow_dest_address   (o_flow_dest_address),
        .i_flow_protocol       (o_flow_protocol),
        .i_flow_source_port    (o_flow_source_port),
        .i_flow_dest_port      (o_flow_dest_port),
        .i_packets_seen        (o_packets_seen),
        .i_bytes_seen          (o_bytes_seen),
        .i_payload_bytes       (o_payload_bytes),
        .o_fail_count          (fail_count),
        .o_pending             (pending)
    );

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic flow_t random_flow();
        flow_t f;
        f.src_addr = $urandom;
        f.dst_addr = $urandom;
        f.proto    = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        f.src_port = 16'($urandom);
        f.dst_port = 16'($urandom);
        return f;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.mode          = 1'($urandom);
        it.flow          = random_flow();
        it.flow.proto    = 8'($urandom);
        it.total_length  = 16'($urandom);
        it.header_words  = 4'($urandom);
        it.tcp_words     = 4'($urandom);
        it.slot_index    = 6'($urandom);
        return it;
    endfunction

    function automatic item_t pkt(input flow_t f, input logic [15:0] tot,
                                  input logic [3:0] hw, input logic [3:0] tw);
        item_t it;
        it              = noise_item();
        it.mode         = MODE_COUNT;
        it.flow         = f;
        it.total_length = tot;
        it.header_words = hw;
        it.tcp_words    = tw;
        return it;
    endfunction

    function automatic item_t rd(input logic [5:0] idx);
        item_t it;
        it            = noise_item();
        it.mode       = MODE_READ;
        it.slot_index = idx;
        return it;
    endfunction

    // Mostly repeats of flows already sent, with some new flows, near misses
    // of known flows, ignored protocols and slot reads.
    function automatic item_t random_item();
        item_t it;
        flow_t f;
        int    pick;
        it      = noise_item();
        it.mode = MODE_COUNT;
        pick    = $urandom_range(0, 99);
        if (pick < 18) begin
            it.mode = MODE_READ;
            return it;
        end
        if (pick < 28) begin
            while (it.flow.proto == PROTO_TCP || it.flow.proto == PROTO_UDP) begin
                it.flow.proto = 8'($urandom);
            end
            return it;
        end
        if (pick < 33 || known_flows.size() == 0) begin
            f = random_flow();
        end else begin
            f = known_flows[$urandom_range(0, known_flows.size() - 1)];
            if (pick < 36) begin
                case ($urandom_range(0, 4))
                    0: f.src_addr = f.src_addr ^ (32'd1 << $urandom_range(0, 31));
                    1: f.dst_addr = f.dst_addr ^ (32'd1 << $urandom_range(0, 31));
                    2: f.proto    = (f.proto == PROTO_TCP) ? PROTO_UDP : PROTO_TCP;
                    3: f.src_port = f.src_port ^ (16'd1 << $urandom_range(0, 15));
                    default: f.dst_port = f.dst_port ^ (16'd1 << $urandom_range(0, 15));
                endcase
            end
        end
        it.flow = f;
        case ($urandom_range(0, 3))
            0: begin
                it.header_words = 4'd5;
                it.tcp_words    = 4'($urandom_range(5, 15));
                it.total_length = 16'($urandom_range(20, 1500));
            end
            1: it.total_length = {10'd0, it.header_words, 2'b00};
            2: ;
            default: it.total_length = 16'($urandom_range(0, 63));
        endcase
        return it;
    endfunction

    task automatic send_item(input item_t it);
        bit seen;
        seen = 1'b0;
        if (it.mode == MODE_COUNT &&
            (it.flow.proto == PROTO_TCP || it.flow.proto == PROTO_UDP)) begin
            foreach (known_flows[k]) begin
                if (known_flows[k] == it.flow) begin
                    seen = 1'b1;
                end
            end
            if (!seen) begin
                known_flows.push_back(it.flow);
            end
        end
        if (!calm && $urandom_range(1, 100) <= gap_rate) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_mode             <= it.mode;
        i_source_address   <= it.flow.src_addr;
        i_dest_address     <= it.flow.dst_addr;
        i_protocol_number  <= it.flow.proto;
        i_source_port      <= it.flow.src_port;
        i_dest_port        <= it.flow.dst_port;
        i_total_length     <= it.total_length;
        i_header_words     <= it.header_words;
        i_tcp_offset_words <= it.tcp_words;
        i_slot_index       <= it.slot_index;
        i_valid            <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_epoch % 256 == 0) begin
            stall_rate = pick_rate();
        end
        stall_epoch++;
        if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(1, 100) <= stall_rate) begin
            stall_left = $urandom_range(0, 13);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        flow_t fa;
        flow_t fb;
        flow_t fx;
        fa = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_TCP, 16'hFFFF, 16'hFFFF};
        fb = '{32'h0, 32'h0, PROTO_UDP, 16'h0, 16'h0};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(rd(6'd0));
        send_item(rd(6'd63));
        fx = random_flow();
        fx.proto = 8'd0;
        send_item(pkt(fx, 16'd100, 4'd5, 4'd5));
        fx.proto = 8'd255;
        send_item(pkt(fx, 16'd100, 4'd5, 4'd5));
        fx.proto = 8'd7;
        send_item(pkt(fx, 16'd100, 4'd5, 4'd5));
        send_item(pkt(fa, 16'hFFFF, 4'd15, 4'd15));
        send_item(pkt(fb, 16'd0, 4'd0, 4'd0));
        send_item(pkt(fa, 16'd20, 4'd5, 4'd15));
        // IP payload shorter than the transport header wraps at 16 bits.
        send_item(pkt(fb, 16'd24, 4'd5, 4'd0));
        send_item(pkt(fb, 16'd10, 4'd5, 4'd0));
        // Flows that differ from a known one in a single field.
        fx = fa;
        fx.proto = PROTO_UDP;
        send_item(pkt(fx, 16'd1500, 4'd5, 4'd5));
        fx = fa;
        fx.dst_port[0] = 1'b0;
        send_item(pkt(fx, 16'd60, 4'd5, 4'd10));
        fx = fa;
        fx.src_addr[31] = 1'b0;
        send_item(pkt(fx, 16'd60, 4'd5, 4'd5));
        fx = fa;
        fx.dst_addr[0] = 1'b0;
        send_item(pkt(fx, 16'd60, 4'd5, 4'd5));
        fx = fa;
        fx.src_port[15] = 1'b0;
        send_item(pkt(fx, 16'd60, 4'd5, 4'd5));
        send_item(pkt(fa, 16'd40, 4'd5, 4'd5));
        send_item(pkt(fb, 16'd28, 4'd5, 4'd0));
        send_item(pkt(fa, 16'd0, 4'd0, 4'd15));
        send_item(rd(6'd0));
        send_item(rd(6'd1));
        send_item(rd(6'd6));
        send_item(rd(6'd7));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                gap_rate = pick_rate();
            end
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            send_item(random_item());
        end
        i_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ftc_pkg.sv
design/ftc_table.sv
design/ftc_update.sv
design/flow_tuple_traffic_counter.sv
sim/ftc_flow_checker.sv
sim/tb_flow_tuple_traffic_counter.sv
